// ----- rtl/core/rccc_pkg.sv -----
// shared types and constants for the row/column checksum corrector
`timescale 1ns / 1ps
`default_nettype none
package rccc_pkg;

    localparam int ROW_LEN_MAX = 64;
    localparam int COL_W       = $clog2(ROW_LEN_MAX);
    localparam int LEN_W       = COL_W + 1;
    localparam int MAX_ROWS    = 128;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ERROR_SLOTS = 4;
    localparam int SLOT_W      = (ERROR_SLOTS > 1) ? $clog2(ERROR_SLOTS) : 1;
    localparam int CNT_W       = $clog2(ERROR_SLOTS + 1);
    localparam int SUM_W       = 16;
    localparam int DIFF_W      = SUM_W + 1;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 7;

    localparam logic [LEN_W-1:0] ROW_LEN_RESET = LEN_W'(50);

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_DATA     = 2'd1,
        CMD_ROW_SUM  = 2'd2,
        CMD_COLUMN   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ROW_SUM = 3'd0,
        KIND_COL_SUM = 3'd1,
        KIND_ROW_ERR = 3'd2,
        KIND_COL_FIX = 3'd3,
        KIND_COL_BAD = 3'd4
    } t_kind;

    typedef enum logic {
        REG_ROW_LENGTH = 1'b0,
        REG_CHECK_MODE = 1'b1
    } t_reg;

    typedef struct packed {
        logic [LEN_W-1:0] row_length;
        logic             check_mode;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   index;
        logic [SUM_W-1:0]   checksum;
        logic [DIFF_W-1:0]  difference;
        logic [ROW_W-1:0]   error_row;
        logic               table_overflow;
    } t_res;

    // work left for the column stage
    typedef struct packed {
        logic               wr;
        logic               col_rd;
        logic               col_chk;
        logic               pre;
        logic [BYTE_W-1:0]  data_byte;
        logic [COL_W-1:0]   addr;
        logic [SUM_W-1:0]   stored;
        t_res               res;
    } t_s1;

    typedef struct packed {
        logic [ERROR_SLOTS-1:0][ROW_W-1:0]  rows;
        logic [ERROR_SLOTS-1:0][DIFF_W-1:0] diffs;
        logic [CNT_W-1:0]                   count;
    } t_tab;

endpackage
`default_nettype wire

// ----- rtl/core/row_column_checksum_corrector_unit.sv -----
// top level of the row/column checksum corrector
//
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tuser: cmd; tdata: byte, stored sum, column
//  m_axis    out  tvalid/tready    tuser: kind; tdata: index, sums, location
//  apb       in   psel/penable     row_length at 0x0, check_mode at 0x4
//
// one beat accepted per cycle unless stalled; a result passes the stage register,
// then the result register. the column sum memory is read at accept and updated as
// the beat leaves the stage register, with a write-first bypass for back-to-back
// beats on the same column. reset is synchronous and active low; column sums come
// out of reset and out of a start beat as zero through per-column valid bits, with
// no clearing pass. a stalled output holds the result register; the input stalls
// only when both the stage register and the result register are full.
`timescale 1ns / 1ps
`default_nettype none
module row_column_checksum_corrector_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] data_byte, [23:8] stored_sum, [29:24] column, [31:30] zero
    input  wire logic [31:0] i_s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [6:0] index, [22:7] checksum, [39:23] difference, [46:40] error_row,
    // [47] table_overflow
    output logic [47:0]      o_m_axis_tdata,
    // [2:0] kind
    output logic [2:0]       o_m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import rccc_pkg::*;

    t_cfg             w_cfg;
    logic             w_acc;
    logic             w_adv;
    logic             w_clr;
    logic             w_re;
    logic [COL_W-1:0] w_raddr;
    logic             w_s1_vld;
    t_s1              w_s1;
    t_tab             w_tab;
    logic             w_we;
    logic [COL_W-1:0] w_waddr;
    logic [SUM_W-1:0] w_wdata;
    logic [SUM_W-1:0] w_rdata;
    logic             w_out_vld;
    t_res             w_res;

    assign o_s_axis_tready = !w_s1_vld || w_adv;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    rccc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rccc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_acc        (w_acc),
        .i_adv        (w_adv),
        .i_cmd        (i_s_axis_tuser),
        .i_data_byte  (i_s_axis_tdata[7:0]),
        .i_stored_sum (i_s_axis_tdata[23:8]),
        .i_column     (i_s_axis_tdata[29:24]),
        .o_clr        (w_clr),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .o_s1_vld     (w_s1_vld),
        .o_s1         (w_s1),
        .o_tab        (w_tab)
    );

    rccc_colmem u_colmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_clr),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    rccc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_vld    (w_s1_vld),
        .i_s1        (w_s1),
        .i_tab       (w_tab),
        .i_rdata     (w_rdata),
        .i_out_ready (i_m_axis_tready),
        .o_adv       (w_adv),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_out_vld   (w_out_vld),
        .o_res       (w_res)
    );

    assign o_m_axis_tvalid = w_out_vld;
    assign o_m_axis_tuser  = w_res.kind;
    assign o_m_axis_tdata  = {w_res.table_overflow, w_res.error_row, w_res.difference,
                              w_res.checksum, w_res.index};

endmodule
`default_nettype wire

// ----- rtl/core/rccc_cfg.sv -----
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none
module rccc_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output rccc_pkg::t_cfg         o_cfg
);
    import rccc_pkg::*;

    t_cfg r_cfg;
    t_reg w_sel;

    assign pready = 1'b1;
    assign w_sel  = t_reg'(paddr[2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_length <= ROW_LEN_RESET;
            r_cfg.check_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_sel)
                REG_ROW_LENGTH: r_cfg.row_length <= pwdata[LEN_W-1:0];
                REG_CHECK_MODE: r_cfg.check_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_ROW_LENGTH: prdata = {{(32-LEN_W){1'b0}}, r_cfg.row_length};
            REG_CHECK_MODE: prdata = {31'b0, r_cfg.check_mode};
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/rccc_front.sv -----
// accept stage: row sums, row counter, error table and stage-one register
`timescale 1ns / 1ps
`default_nettype none
module rccc_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rccc_pkg::t_cfg              i_cfg,
    input  wire logic                        i_acc,
    input  wire logic                        i_adv,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [rccc_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic [rccc_pkg::SUM_W-1:0]  i_stored_sum,
    input  wire logic [rccc_pkg::COL_W-1:0]  i_column,
    output logic                             o_clr,
    output logic                             o_re,
    output logic [rccc_pkg::COL_W-1:0]       o_raddr,
    output logic                             o_s1_vld,
    output rccc_pkg::t_s1                    o_s1,
    output rccc_pkg::t_tab                   o_tab
);
    import rccc_pkg::*;

    t_cmd              w_cmd;
    logic [LEN_W-1:0]  w_len;
    logic [SUM_W-1:0]  w_sum_add;
    logic [DIFF_W-1:0] w_row_diff;
    logic              w_row_end;
    logic              w_full;

    logic [SUM_W-1:0]  r_row_sum,  n_row_sum;
    logic [COL_W-1:0]  r_col_pos,  n_col_pos;
    logic [ROW_W-1:0]  r_row_cnt,  n_row_cnt;
    logic [SUM_W-1:0]  r_done_sum, n_done_sum;
    logic [CNT_W-1:0]  r_err_cnt,  n_err_cnt;
    logic              n_tab_we;
    logic [ERROR_SLOTS-1:0][ROW_W-1:0]  r_err_rows;
    logic [ERROR_SLOTS-1:0][DIFF_W-1:0] r_err_diffs;
    logic              r_s1_vld;
    t_s1               r_s1, n_s1;

    assign w_cmd = t_cmd'(i_cmd);

    // effective row length, 0 acts as 1 and large values clamp to the max
    always_comb begin
        if (i_cfg.row_length == '0)
            w_len = LEN_W'(1);
        else if (i_cfg.row_length > LEN_W'(ROW_LEN_MAX))
            w_len = LEN_W'(ROW_LEN_MAX);
        else
            w_len = i_cfg.row_length;
    end

    assign w_sum_add  = r_row_sum + {{(SUM_W-BYTE_W){1'b0}}, i_data_byte};
    assign w_row_end  = ({1'b0, r_col_pos} + LEN_W'(1)) >= w_len;
    assign w_row_diff = {1'b0, i_stored_sum} - {1'b0, r_done_sum};
    assign w_full     = r_err_cnt >= CNT_W'(ERROR_SLOTS);

    always_comb begin
        n_row_sum  = r_row_sum;
        n_col_pos  = r_col_pos;
        n_row_cnt  = r_row_cnt;
        n_done_sum = r_done_sum;
        n_err_cnt  = r_err_cnt;
        n_tab_we   = 1'b0;
        n_s1       = '0;
        n_s1.data_byte = i_data_byte;
        n_s1.stored    = i_stored_sum;
        n_s1.addr      = i_column;
        unique case (w_cmd)
            CMD_START: begin
                n_row_sum  = '0;
                n_col_pos  = '0;
                n_row_cnt  = '0;
                n_done_sum = '0;
                n_err_cnt  = '0;
            end
            CMD_DATA: begin
                n_s1.wr   = 1'b1;
                n_s1.addr = r_col_pos;
                if (w_row_end) begin
                    n_row_sum = '0;
                    n_col_pos = '0;
                    if (i_cfg.check_mode) begin
                        n_done_sum = w_sum_add;
                    end else begin
                        n_s1.pre          = 1'b1;
                        n_s1.res.kind     = KIND_ROW_SUM;
                        n_s1.res.index    = IDX_W'(r_row_cnt);
                        n_s1.res.checksum = w_sum_add;
                        n_row_cnt         = r_row_cnt + ROW_W'(1);
                    end
                end else begin
                    n_row_sum = w_sum_add;
                    n_col_pos = r_col_pos + COL_W'(1);
                end
            end
            CMD_ROW_SUM: begin
                if (i_cfg.check_mode) begin
                    n_row_cnt = r_row_cnt + ROW_W'(1);
                    if (w_row_diff != '0) begin
                        n_s1.pre                = 1'b1;
                        n_s1.res.kind           = KIND_ROW_ERR;
                        n_s1.res.index          = IDX_W'(r_row_cnt);
                        n_s1.res.difference     = w_row_diff;
                        n_s1.res.table_overflow = w_full;
                        if (!w_full) begin
                            n_tab_we  = 1'b1;
                            n_err_cnt = r_err_cnt + CNT_W'(1);
                        end
                    end
                end
            end
            CMD_COLUMN: begin
                n_s1.col_rd  = !i_cfg.check_mode;
                n_s1.col_chk = i_cfg.check_mode;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum  <= '0;
            r_col_pos  <= '0;
            r_row_cnt  <= '0;
            r_done_sum <= '0;
            r_err_cnt  <= '0;
            r_s1_vld   <= 1'b0;
        end else if (i_acc) begin
            r_row_sum  <= n_row_sum;
            r_col_pos  <= n_col_pos;
            r_row_cnt  <= n_row_cnt;
            r_done_sum <= n_done_sum;
            r_err_cnt  <= n_err_cnt;
            r_s1_vld   <= 1'b1;
        end else if (i_adv) begin
            r_s1_vld   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1 <= n_s1;
            if (n_tab_we) begin
                r_err_rows[r_err_cnt[SLOT_W-1:0]]  <= r_row_cnt;
                r_err_diffs[r_err_cnt[SLOT_W-1:0]] <= w_row_diff;
            end
        end
    end

    assign o_clr   = i_acc && (w_cmd == CMD_START);
    assign o_re    = i_acc && ((w_cmd == CMD_DATA) || (w_cmd == CMD_COLUMN));
    assign o_raddr = n_s1.addr;

    assign o_s1_vld    = r_s1_vld;
    assign o_s1        = r_s1;
    assign o_tab.rows  = r_err_rows;
    assign o_tab.diffs = r_err_diffs;
    assign o_tab.count = r_err_cnt;

endmodule
`default_nettype wire

// ----- rtl/core/rccc_colmem.sv -----
// column sum memory with per-entry valid bits and write-first read bypass
`timescale 1ns / 1ps
`default_nettype none
module rccc_colmem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clr,
    input  wire logic                       i_re,
    input  wire logic [rccc_pkg::COL_W-1:0] i_raddr,
    input  wire logic                       i_we,
    input  wire logic [rccc_pkg::COL_W-1:0] i_waddr,
    input  wire logic [rccc_pkg::SUM_W-1:0] i_wdata,
    output logic      [rccc_pkg::SUM_W-1:0] o_rdata
);
    import rccc_pkg::*;

    logic [SUM_W-1:0]       r_mem [ROW_LEN_MAX];
    logic [ROW_LEN_MAX-1:0] r_vld;
    logic [SUM_W-1:0]       r_q;
    logic                   r_qv;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr))
                r_q <= i_wdata;
            else
                r_q <= r_mem[i_raddr];
        end
    end

    // start of block wins over a write from the item ahead of it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_clr)
                r_vld <= '0;
            else if (i_we)
                r_vld[i_waddr] <= 1'b1;
            if (i_re)
                r_qv <= (i_we && (i_waddr == i_raddr)) || r_vld[i_raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule
`default_nettype wire

// ----- rtl/core/rccc_back.sv -----
// column stage: column update, column check with table search, result register
`timescale 1ns / 1ps
`default_nettype none
module rccc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s1_vld,
    input  wire rccc_pkg::t_s1              i_s1,
    input  wire rccc_pkg::t_tab             i_tab,
    input  wire logic [rccc_pkg::SUM_W-1:0] i_rdata,
    input  wire logic                       i_out_ready,
    output logic                            o_adv,
    output logic                            o_we,
    output logic      [rccc_pkg::COL_W-1:0] o_waddr,
    output logic      [rccc_pkg::SUM_W-1:0] o_wdata,
    output logic                            o_out_vld,
    output rccc_pkg::t_res                  o_res
);
    import rccc_pkg::*;

    logic              r_out_vld;
    t_res              r_out;
    t_res              w_res;
    logic              w_have;
    logic [DIFF_W-1:0] w_diff;
    logic              w_hit;
    logic [ROW_W-1:0]  w_hit_row;

    assign o_adv   = !r_out_vld || i_out_ready;
    assign o_we    = i_s1_vld && o_adv && i_s1.wr;
    assign o_waddr = i_s1.addr;
    assign o_wdata = i_rdata + {{(SUM_W-BYTE_W){1'b0}}, i_s1.data_byte};

    assign w_diff = {1'b0, i_s1.stored} - {1'b0, i_rdata};

    // first recorded row mismatch with the same difference
    always_comb begin
        w_hit     = 1'b0;
        w_hit_row = '0;
        for (int i = ERROR_SLOTS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < i_tab.count) && (i_tab.diffs[i] == w_diff)) begin
                w_hit     = 1'b1;
                w_hit_row = i_tab.rows[i];
            end
        end
    end

    always_comb begin
        w_res  = '0;
        w_have = 1'b0;
        if (i_s1.pre) begin
            w_res  = i_s1.res;
            w_have = 1'b1;
        end else if (i_s1.col_rd) begin
            w_res.kind     = KIND_COL_SUM;
            w_res.index    = {1'b0, i_s1.addr};
            w_res.checksum = i_rdata;
            w_have         = 1'b1;
        end else if (i_s1.col_chk && (w_diff != '0)) begin
            w_res.index      = {1'b0, i_s1.addr};
            w_res.difference = w_diff;
            w_have           = 1'b1;
            if (w_hit) begin
                w_res.kind      = KIND_COL_FIX;
                w_res.error_row = w_hit_row;
            end else begin
                w_res.kind      = KIND_COL_BAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= i_s1_vld && w_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv)
            r_out <= w_res;
    end

    assign o_out_vld = r_out_vld;
    assign o_res     = r_out;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the row/column checksum corrector: directed table, then random blocks
module tb_top;
    import rccc_pkg::*;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data_byte;
        logic [15:0] stored;
        logic [5:0]  column;
    } t_beat;

    typedef struct {
        bit         is_cfg;
        t_reg       addr_sel;
        logic [6:0] value;
        t_beat      beat;
        bit         typed;
        t_res       want;
    } t_step;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    // [7:0] data_byte, [23:8] stored_sum, [29:24] column, [31:30] zero
    logic [31:0] s_data  = '0;
    // [1:0] cmd
    logic [1:0]  s_user  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    // [6:0] index, [22:7] checksum, [39:23] difference, [46:40] error_row, [47] table_overflow
    logic [47:0] m_data;
    // [2:0] kind
    logic [2:0]  m_user;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    always #5 i_clk = ~i_clk;

    row_column_checksum_corrector_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // predicted block state
    logic [6:0]  cfg_len;
    logic        cfg_check;
    logic [15:0] run_sum;
    logic [5:0]  col_pos;
    logic [6:0]  row_idx;
    logic [15:0] col_sums [64];
    logic [6:0]  err_rows [4];
    int          err_diffs [4];
    int          err_cnt;
    logic [15:0] done_sum;

    t_res        pending_reports [$];
    t_res        oldest;
    int          mismatches;
    int          beats_done;
    bit          tx_calm;
    bit          rx_calm;
    int          rx_hold;
    t_step       directed [$];

    function automatic void clear_block();
        run_sum  = '0;
        col_pos  = '0;
        row_idx  = '0;
        done_sum = '0;
        err_cnt  = 0;
        for (int i = 0; i < 64; i++) col_sums[i] = '0;
        for (int i = 0; i < 4; i++) begin
            err_rows[i]  = '0;
            err_diffs[i] = 0;
        end
    endfunction

    function automatic t_res make_res(t_kind k, int idx, int sum, int diff, int erow, bit ovf);
        t_res r;
        r.kind           = k;
        r.index          = 7'(idx);
        r.checksum       = 16'(sum);
        r.difference     = 17'(diff);
        r.error_row      = 7'(erow);
        r.table_overflow = ovf;
        return r;
    endfunction

    function automatic t_beat make_beat(t_cmd c, int db, int st, int col);
        t_beat b;
        b.cmd       = c;
        b.data_byte = 8'(db);
        b.stored    = 16'(st);
        b.column    = 6'(col);
        return b;
    endfunction

    function automatic int eff_len();
        if (cfg_len == 0) return 1;
        if (cfg_len > 64) return 64;
        return int'(cfg_len);
    endfunction

    // returns 1 when the beat produces a report
    function automatic bit checksum_step(input t_beat b, output t_res r);
        int pos;
        int d;
        r = '0;
        case (b.cmd)
            CMD_START: begin
                clear_block();
                return 0;
            end
            CMD_DATA: begin
                pos = int'(col_pos);
                run_sum = run_sum + b.data_byte;
                col_sums[pos] = col_sums[pos] + b.data_byte;
                if (pos + 1 >= eff_len()) begin
                    r = make_res(KIND_ROW_SUM, row_idx, run_sum, 0, 0, 0);
                    col_pos = '0;
                    if (cfg_check) begin
                        done_sum = run_sum;
                        run_sum  = '0;
                        return 0;
                    end
                    run_sum = '0;
                    row_idx = row_idx + 1'b1;
                    return 1;
                end
                col_pos = 6'(pos + 1);
                return 0;
            end
            CMD_ROW_SUM: begin
                if (!cfg_check) return 0;
                d = int'(b.stored) - int'(done_sum);
                pos = int'(row_idx);
                row_idx = row_idx + 1'b1;
                if (d == 0) return 0;
                if (err_cnt < 4) begin
                    err_rows[err_cnt]  = 7'(pos);
                    err_diffs[err_cnt] = d;
                    err_cnt++;
                    r = make_res(KIND_ROW_ERR, pos, 0, d, 0, 1'b0);
                end else begin
                    r = make_res(KIND_ROW_ERR, pos, 0, d, 0, 1'b1);
                end
                return 1;
            end
            default: begin
                if (!cfg_check) begin
                    r = make_res(KIND_COL_SUM, b.column, col_sums[b.column], 0, 0, 0);
                    return 1;
                end
                d = int'(b.stored) - int'(col_sums[b.column]);
                if (d == 0) return 0;
                // first table entry with the same difference locates the byte
                for (int i = 0; i < err_cnt; i++) begin
                    if (err_diffs[i] == d) begin
                        r = make_res(KIND_COL_FIX, b.column, 0, d, err_rows[i], 0);
                        return 1;
                    end
                end
                r = make_res(KIND_COL_BAD, b.column, 0, d, 0, 0);
                return 1;
            end
        endcase
    endfunction

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic t_step cfg_step(t_reg a, int v);
        t_step s;
        s.is_cfg   = 1'b1;
        s.addr_sel = a;
        s.value    = 7'(v);
        s.beat     = '0;
        s.typed    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    function automatic t_step beat_step(t_cmd c, int db, int st, int col);
        t_step s;
        s.is_cfg   = 1'b0;
        s.addr_sel = REG_ROW_LENGTH;
        s.value    = '0;
        s.beat     = make_beat(c, db, st, col);
        s.typed    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    function automatic t_step typed_step(t_cmd c, int db, int st, int col, t_kind k, int idx,
                                         int sum, int diff, int erow, bit ovf);
        t_step s;
        s = beat_step(c, db, st, col);
        s.typed = 1'b1;
        s.want  = make_res(k, idx, sum, diff, erow, ovf);
        return s;
    endfunction

    task automatic send_beat(input t_beat b, input bit typed = 1'b0, input t_res want = '0);
        int   g;
        bit   has;
        t_res r;
        g = tx_calm ? 0 : idle_len();
        repeat (g) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= b.cmd;
        s_data  <= {2'b00, b.column, b.stored, b.data_byte};
        do @(posedge i_clk); while (!s_ready);
        if (!(b.cmd == CMD_ROW_SUM && !cfg_check)) beats_done++;
        has = checksum_step(b, r);
        if (typed) pending_reports.push_back(want);
        else if (has) pending_reports.push_back(r);
    endtask

    // hold the stream until every report is back, then let the pipeline drain
    task automatic settle();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg a, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {a, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (a == REG_ROW_LENGTH) cfg_len = v[6:0];
        else cfg_check = v[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int pick_byte(bit heavy);
        int p;
        p = $urandom_range(0, 99);
        if (heavy) return (p < 75) ? 8'hFF : $urandom_range(0, 255);
        if (p < 20) return 8'hFF;
        if (p < 30) return 0;
        return $urandom_range(0, 255);
    endfunction

    task automatic send_noise();
        t_cmd c;
        c = ($urandom_range(0, 39) == 0) ? CMD_START : t_cmd'($urandom_range(1, 3));
        send_beat(make_beat(c, $urandom, $urandom, $urandom));
    endtask

    // one block: configure, optionally start, rows, column beats, sometimes a partial row
    task automatic run_block(input int force_len, input int force_mode, input int force_rows);
        int          len_v;
        int          mode_v;
        int          eff;
        int          rows;
        int          p;
        int          c;
        logic [15:0] st;
        if (force_len >= 0) begin
            len_v = force_len;
        end else begin
            p = $urandom_range(0, 99);
            if (p < 8) len_v = 0;
            else if (p < 16) len_v = 1;
            else if (p < 24) len_v = $urandom_range(2, 3);
            else if (p < 30) len_v = 64;
            else if (p < 33) len_v = $urandom_range(65, 127);
            else if (p < 40) len_v = $urandom_range(13, 63);
            else len_v = $urandom_range(1, 12);
        end
        mode_v = (force_mode >= 0) ? force_mode : $urandom_range(0, 1);
        settle();
        write_reg(REG_ROW_LENGTH, len_v);
        write_reg(REG_CHECK_MODE, mode_v);
        eff = eff_len();
        tx_calm = ($urandom_range(0, 3) == 0);
        if (force_rows > 0 || $urandom_range(0, 4) != 0)
            send_beat(make_beat(CMD_START, $urandom, $urandom, $urandom));
        if (force_rows > 0) rows = force_rows;
        else rows = (eff >= 24) ? $urandom_range(1, 3) : $urandom_range(1, 10);
        repeat (rows) begin
            do begin
                if (force_rows == 0 && $urandom_range(0, 19) == 0) send_noise();
                send_beat(make_beat(CMD_DATA, pick_byte(force_rows > 0), $urandom, $urandom));
            end while (col_pos != 0);
            if (cfg_check) begin
                p = $urandom_range(0, 99);
                if (p < 70) st = done_sum;
                else if (p < 80) st = done_sum + 16'($urandom_range(1, 255));
                else if (p < 90) st = done_sum - 16'($urandom_range(1, 255));
                else st = 16'($urandom);
                send_beat(make_beat(CMD_ROW_SUM, $urandom, st, $urandom));
            end
        end
        repeat ($urandom_range(1, 6)) begin
            c = ($urandom_range(0, 9) < 7) ? $urandom_range(0, eff - 1) : $urandom_range(0, 63);
            p = $urandom_range(0, 99);
            if (p < 55) st = col_sums[c];
            else if (p < 80 && err_cnt > 0)
                st = col_sums[c] + 16'(err_diffs[$urandom_range(0, err_cnt - 1)]);
            else st = 16'($urandom);
            send_beat(make_beat(CMD_COLUMN, $urandom, st, c));
        end
        // sometimes leave a row half filled for the next setting
        if (eff > 1 && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, eff - 1))
                send_beat(make_beat(CMD_DATA, pick_byte(1'b0), $urandom, $urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            rx_hold = rx_calm ? 0 : idle_len();
            m_ready <= (rx_hold == 0);
            if (rx_hold > 0) rx_hold--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report with none pending: kind %0d index %0d", m_user, m_data[6:0]);
                mismatches++;
            end else begin
                oldest = pending_reports.pop_front();
                check_field("kind", oldest.kind, m_user);
                check_field("index", oldest.index, m_data[6:0]);
                check_field("checksum", oldest.checksum, m_data[22:7]);
                check_field("difference", oldest.difference, m_data[39:23]);
                check_field("error_row", oldest.error_row, m_data[46:40]);
                check_field("table_overflow", oldest.table_overflow, m_data[47]);
            end
        end
    end

    initial begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int waited;
        mismatches = 0;
        beats_done = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        rx_hold    = 0;
        cfg_len    = 7'd50;
        cfg_check  = 1'b0;
        clear_block();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{
            typed_step(CMD_COLUMN, 0, 0, 0, KIND_COL_SUM, 0, 0, 0, 0, 0),
            cfg_step(REG_ROW_LENGTH, 2),
            cfg_step(REG_CHECK_MODE, 0),
            beat_step(CMD_START, 0, 0, 0),
            beat_step(CMD_DATA, 8'hFF, 0, 0),
            typed_step(CMD_DATA, 8'hFF, 0, 0, KIND_ROW_SUM, 0, 16'h01FE, 0, 0, 0),
            beat_step(CMD_DATA, 8'h00, 0, 0),
            typed_step(CMD_DATA, 8'h01, 0, 0, KIND_ROW_SUM, 1, 1, 0, 0, 0),
            typed_step(CMD_COLUMN, 0, 0, 0, KIND_COL_SUM, 0, 16'h00FF, 0, 0, 0),
            typed_step(CMD_COLUMN, 0, 0, 1, KIND_COL_SUM, 1, 16'h0100, 0, 0, 0),
            typed_step(CMD_COLUMN, 0, 16'hFFFF, 63, KIND_COL_SUM, 63, 0, 0, 0, 0),
            // stored row sums are ignored while encoding
            beat_step(CMD_ROW_SUM, 0, 16'h1234, 0),
            cfg_step(REG_CHECK_MODE, 1),
            cfg_step(REG_ROW_LENGTH, 1),
            beat_step(CMD_START, 0, 0, 0),
            beat_step(CMD_DATA, 8'h10, 0, 0),
            beat_step(CMD_ROW_SUM, 0, 16'h0010, 0),
            beat_step(CMD_DATA, 8'h20, 0, 0),
            typed_step(CMD_ROW_SUM, 0, 16'hFFFF, 0, KIND_ROW_ERR, 1, 0, 65503, 0, 0),
            beat_step(CMD_DATA, 8'hFF, 0, 0),
            typed_step(CMD_ROW_SUM, 0, 0, 0, KIND_ROW_ERR, 2, 0, -255, 0, 0),
            beat_step(CMD_ROW_SUM, 0, 0, 0),
            beat_step(CMD_ROW_SUM, 0, 1, 0),
            // error table full: reported but dropped
            typed_step(CMD_ROW_SUM, 0, 0, 0, KIND_ROW_ERR, 5, 0, -255, 0, 1),
            beat_step(CMD_COLUMN, 0, 16'h012F, 0),
            beat_step(CMD_COLUMN, 0, 16'h0030, 0),
            beat_step(CMD_COLUMN, 0, 16'hFFFF, 0),
            typed_step(CMD_COLUMN, 0, 16'hFFFF, 63, KIND_COL_BAD, 63, 0, 65535, 0, 0),
            // zero row length acts as one byte per row
            cfg_step(REG_ROW_LENGTH, 0),
            beat_step(CMD_DATA, 8'hAA, 0, 0),
            beat_step(CMD_ROW_SUM, 0, 16'h00AA, 0)
        };
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                settle();
                write_reg(directed[i].addr_sel, 32'(directed[i].value));
            end else begin
                send_beat(directed[i].beat, directed[i].typed, directed[i].want);
            end
        end

        beats_done = 0;
        // long single-byte blocks wrap the row counter and the column sum
        run_block(1, 0, 300);
        run_block(1, 1, 135);
        run_block(64, 1, 0);
        run_block(64, 0, 0);
        while (beats_done < 1550) run_block(-1, -1, 0);

        @(negedge i_clk);
        s_valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $error("%0d reports never arrived", pending_reports.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
